@@ design/aegs_pkg.sv @@
// ----------------------------------------------------------------------------
// aegs_pkg: shared types and constants of the gain stepper
// Widths, register indexes, reset values, thresholds and the job record that
// passes from the frame accumulator to the divide-and-step engine.
// ----------------------------------------------------------------------------
package aegs_pkg;

    // Longest frame that is accumulated; later bytes are ignored
    localparam int STATS_LEN = 256;
    localparam int CNT_W     = $clog2(STATS_LEN + 1);

    // Fixed field widths
    localparam int SUM_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int TGT_W     = 8;
    localparam int OUT_CNT_W = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIFF_W    = GAIN_W + 2;
    localparam int BIT_W     = $clog2(SUM_W);

    // Job queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

    // Mode codes
    localparam logic MODE_EXPOSURE = 1'b0;
    localparam logic MODE_BALANCE  = 1'b1;

    // Register reset values
    localparam logic [TGT_W-1:0]  TARGET_RESET = 8'd80;
    localparam logic [GAIN_W-1:0] LIMIT_RESET  = 16'd512;

    // Dead-band thresholds and gain steps
    localparam int THR_SMALL  = 10;
    localparam int THR_MID    = 20;
    localparam int THR_LARGE  = 30;
    localparam int STEP_SMALL = 1;
    localparam int STEP_MID   = 5;
    localparam int STEP_LARGE = 10;

    // One finished frame, ready for the back end
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  divisor;
        logic [GAIN_W-1:0] cur_gain;
        logic              mode;
        logic [TGT_W-1:0]  target;
        logic [GAIN_W-1:0] limit;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_FINISH
    } back_state_t;

endpackage

@@ design/aegs_front.sv @@
// ----------------------------------------------------------------------------
// aegs_front: frame accumulator and configuration registers
// Takes one statistics byte per cycle unless stalled, keeps sum, count and the
// position past the last nonzero byte, and queues a job at the frame's end.
// ----------------------------------------------------------------------------
module aegs_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [aegs_pkg::BYTE_W-1:0]      stat_byte,
    input  logic                             frame_last,
    input  logic [aegs_pkg::GAIN_W-1:0]      current_gain,
    input  logic                             cfg_we,
    input  logic [aegs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aegs_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             job_full,
    output logic                             job_push,
    output aegs_pkg::job_t                   job
);

    logic                          mode_reg;
    logic [aegs_pkg::TGT_W-1:0]    target_reg;
    logic [aegs_pkg::GAIN_W-1:0]   limit_reg;

    logic [aegs_pkg::SUM_W-1:0]    sum_reg,   sum_next;
    logic [aegs_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [aegs_pkg::CNT_W-1:0]    pos_reg,   pos_next;
    logic [aegs_pkg::SUM_W:0]      sum_ext;
    logic                          accept;

    // Stall only while the queue has no room
    assign in_stall = job_full;
    assign accept   = in_valid && !job_full;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= aegs_pkg::MODE_EXPOSURE;
            target_reg <= aegs_pkg::TARGET_RESET;
            limit_reg  <= aegs_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aegs_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                aegs_pkg::REG_TARGET: target_reg <= cfg_data[aegs_pkg::TGT_W-1:0];
                aegs_pkg::REG_LIMIT:  limit_reg  <= cfg_data[aegs_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Fold the incoming byte into the running totals
    always_comb
    begin
        sum_ext    = {1'b0, sum_reg} + (aegs_pkg::SUM_W + 1)'(stat_byte);
        sum_next   = sum_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        if (count_reg < aegs_pkg::CNT_W'(aegs_pkg::STATS_LEN))
        begin
            count_next = count_reg + 1'b1;
            if (stat_byte != '0)
            begin
                pos_next = count_reg + 1'b1;
            end
            sum_next = sum_ext[aegs_pkg::SUM_W] ? '1 : sum_ext[aegs_pkg::SUM_W-1:0];
        end
    end

    // Advance the totals; clear them after the frame's last item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_last)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                pos_reg   <= pos_next;
            end
        end
    end

    // Build the job for the back end
    assign job_push     = accept && frame_last;
    assign job.sum      = sum_next;
    assign job.divisor  = (mode_reg == aegs_pkg::MODE_EXPOSURE) ? pos_next : count_next;
    assign job.cur_gain = current_gain;
    assign job.mode     = mode_reg;
    assign job.target   = target_reg;
    assign job.limit    = limit_reg;

endmodule

@@ design/aegs_queue.sv @@
// ----------------------------------------------------------------------------
// aegs_queue: short job queue between front and back
// A small first-in first-out store of finished frames.
// ----------------------------------------------------------------------------
module aegs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aegs_pkg::job_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output aegs_pkg::job_t  pop_data
);

    aegs_pkg::job_t                 entry_reg [aegs_pkg::QUEUE_DEPTH];
    logic [aegs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [aegs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [aegs_pkg::QCNT_W-1:0]    fill_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full      = (fill_reg == aegs_pkg::QCNT_W'(aegs_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Wrap the pointers at the depth
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == aegs_pkg::QPTR_W'(aegs_pkg::QUEUE_DEPTH - 1))
                      ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == aegs_pkg::QPTR_W'(aegs_pkg::QUEUE_DEPTH - 1))
                      ? '0 : rd_ptr_reg + 1'b1;
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/aegs_back.sv @@
// ----------------------------------------------------------------------------
// aegs_back: divide and gain-step engine
// Takes one job, divides the sum one quotient bit per cycle, picks the gain
// step, clamps, and loads the output register (balance mode: the average).
// ----------------------------------------------------------------------------
module aegs_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_ready,
    input  aegs_pkg::job_t                     job,
    output logic                               job_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [aegs_pkg::GAIN_W-1:0]        result_value,
    output logic [aegs_pkg::OUT_CNT_W-1:0]     valid_count
);

    aegs_pkg::back_state_t              state_reg, state_next;

    logic [aegs_pkg::SUM_W-1:0]         quo_reg;
    logic [aegs_pkg::CNT_W-1:0]         rem_reg;
    logic [aegs_pkg::CNT_W-1:0]         divisor_reg;
    logic [aegs_pkg::BIT_W-1:0]         bit_reg;
    logic [aegs_pkg::GAIN_W-1:0]        cur_reg;
    logic                               mode_reg;
    logic [aegs_pkg::TGT_W-1:0]         target_reg;
    logic [aegs_pkg::GAIN_W-1:0]        limit_reg;

    logic                               out_valid_reg;
    logic [aegs_pkg::GAIN_W-1:0]        result_reg;
    logic [aegs_pkg::OUT_CNT_W-1:0]     count_reg;

    logic [aegs_pkg::CNT_W:0]           shifted;
    logic [aegs_pkg::CNT_W:0]           diff_sub;
    logic                               fits;
    logic [aegs_pkg::CNT_W-1:0]         rem_step;
    logic [aegs_pkg::SUM_W-1:0]         quo_step;

    logic [aegs_pkg::SUM_W-1:0]         avg;
    logic signed [aegs_pkg::DIFF_W-1:0] level_diff;
    logic signed [aegs_pkg::DIFF_W-1:0] gain_sum;
    logic signed [aegs_pkg::DIFF_W-1:0] gain_clamped;
    logic signed [aegs_pkg::DIFF_W-1:0] limit_s;
    logic [aegs_pkg::GAIN_W-1:0]        gain_value;
    logic [aegs_pkg::GAIN_W-1:0]        final_value;

    logic                               load_job;
    logic                               load_out;
    logic                               last_bit;

    // Pick the gain step from the dead band
    function automatic logic signed [aegs_pkg::DIFF_W-1:0] gain_step(
        input logic signed [aegs_pkg::DIFF_W-1:0] diff
    );
        logic signed [aegs_pkg::DIFF_W-1:0] step;
        step = '0;
        if (diff > 0)
        begin
            if (diff < aegs_pkg::THR_SMALL)       step = '0;
            else if (diff < aegs_pkg::THR_MID)    step = aegs_pkg::DIFF_W'(aegs_pkg::STEP_SMALL);
            else if (diff < aegs_pkg::THR_LARGE)  step = aegs_pkg::DIFF_W'(aegs_pkg::STEP_MID);
            else                                  step = aegs_pkg::DIFF_W'(aegs_pkg::STEP_LARGE);
        end
        else
        begin
            if (diff > -aegs_pkg::THR_SMALL)      step = '0;
            else if (diff > -aegs_pkg::THR_MID)   step = aegs_pkg::DIFF_W'(-aegs_pkg::STEP_SMALL);
            else if (diff > -aegs_pkg::THR_LARGE) step = aegs_pkg::DIFF_W'(-aegs_pkg::STEP_MID);
            else                                  step = aegs_pkg::DIFF_W'(-aegs_pkg::STEP_LARGE);
        end
        return step;
    endfunction

    // One restoring divide step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[aegs_pkg::SUM_W-1]};
        diff_sub = shifted - {1'b0, divisor_reg};
        fits     = (shifted >= {1'b0, divisor_reg});
        rem_step = fits ? diff_sub[aegs_pkg::CNT_W-1:0] : shifted[aegs_pkg::CNT_W-1:0];
        quo_step = {quo_reg[aegs_pkg::SUM_W-2:0], fits};
    end

    // Step the gain and clamp it; an all-zero divisor gives a zero average
    always_comb
    begin
        avg          = (divisor_reg == '0) ? '0 : quo_reg;
        level_diff   = $signed({{(aegs_pkg::DIFF_W - aegs_pkg::TGT_W){1'b0}}, target_reg})
                     - $signed({{(aegs_pkg::DIFF_W - aegs_pkg::SUM_W){1'b0}}, avg});
        gain_sum     = $signed({{(aegs_pkg::DIFF_W - aegs_pkg::GAIN_W){1'b0}}, cur_reg})
                     + gain_step(level_diff);
        limit_s      = $signed({{(aegs_pkg::DIFF_W - aegs_pkg::GAIN_W){1'b0}}, limit_reg});
        gain_clamped = (gain_sum > limit_s) ? limit_s : gain_sum;
        gain_value   = (gain_clamped > 0) ? gain_clamped[aegs_pkg::GAIN_W-1:0] : cur_reg;
        final_value  = (mode_reg == aegs_pkg::MODE_BALANCE) ? avg : gain_value;
    end

    // Sequencer: next state and control
    always_comb
    begin
        state_next = state_reg;
        load_job   = 1'b0;
        load_out   = 1'b0;
        last_bit   = (bit_reg == aegs_pkg::BIT_W'(aegs_pkg::SUM_W - 1));
        case (state_reg)
            aegs_pkg::BK_IDLE:
            begin
                if (job_ready)
                begin
                    load_job   = 1'b1;
                    state_next = aegs_pkg::BK_DIVIDE;
                end
            end
            aegs_pkg::BK_DIVIDE:
            begin
                if (last_bit)
                begin
                    state_next = aegs_pkg::BK_FINISH;
                end
            end
            aegs_pkg::BK_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = aegs_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = aegs_pkg::BK_IDLE;
            end
        endcase
    end

    assign job_pop = load_job;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aegs_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Load a job, then advance the divider
    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            quo_reg     <= job.sum;
            rem_reg     <= '0;
            divisor_reg <= job.divisor;
            bit_reg     <= '0;
            cur_reg     <= job.cur_gain;
            mode_reg    <= job.mode;
            target_reg  <= job.target;
            limit_reg   <= job.limit;
        end
        else if (state_reg == aegs_pkg::BK_DIVIDE)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
            bit_reg <= bit_reg + 1'b1;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg <= final_value;
            count_reg  <= aegs_pkg::OUT_CNT_W'(divisor_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign valid_count  = count_reg;

endmodule

@@ design/auto_exposure_gain_stepper_unit.sv @@
// After its frame's last item is accepted, the back end loads the job from the queue,
// runs 16 one-bit divide steps, then steps the gain and loads the output.
// Throughput: one statistics byte per cycle while the job queue has room; the back end
// takes one job at a time, and the two-entry job queue absorbs short frames.
// Reset clears the accumulators, queue and output; registers return to mode 0,
// target 80, limit 512.
// ----------------------------------------------------------------------------
// auto_exposure_gain_stepper_unit: auto exposure / white balance gain stepper
// Accumulates statistics bytes per frame, then divides and steps the gain (or, in balance mode, gives the average).
// ----------------------------------------------------------------------------
module auto_exposure_gain_stepper_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [aegs_pkg::BYTE_W-1:0]        stat_byte,
    input  logic                               frame_last,
    input  logic [aegs_pkg::GAIN_W-1:0]        current_gain,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [aegs_pkg::GAIN_W-1:0]        result_value,
    output logic [aegs_pkg::OUT_CNT_W-1:0]     valid_count,
    input  logic                               cfg_we,
    input  logic [aegs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aegs_pkg::CFG_W-1:0]         cfg_data
);

    logic            job_push;
    logic            job_full;
    logic            job_ready;
    logic            job_pop;
    aegs_pkg::job_t  front_job;
    aegs_pkg::job_t  queued_job;

    // Front: accumulate the frame
    aegs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .stat_byte    (stat_byte),
        .frame_last   (frame_last),
        .current_gain (current_gain),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .job_full     (job_full),
        .job_push     (job_push),
        .job          (front_job)
    );

    // Queue of finished frames
    aegs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (front_job),
        .full      (job_full),
        .pop       (job_pop),
        .not_empty (job_ready),
        .pop_data  (queued_job)
    );

    // Back: divide and step
    aegs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_ready    (job_ready),
        .job          (queued_job),
        .job_pop      (job_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .valid_count  (valid_count)
    );

endmodule

@@ design/aegs_checker.sv @@
// ----------------------------------------------------------------------------
// aegs_checker: port-level checks of the gain stepper
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module aegs_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [aegs_pkg::GAIN_W-1:0]        result_value,
    input  logic [aegs_pkg::OUT_CNT_W-1:0]     valid_count
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
                                   && $stable(valid_count))
        else $error("stalled result changed or dropped");

    // Count never passes the frame length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> valid_count <= aegs_pkg::OUT_CNT_W'(aegs_pkg::STATS_LEN))
        else $error("valid_count beyond frame length");

    // In reset, no output is valid and the input is not stalled
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("output or stall active in reset");

    // Leaving reset, the queue has room
    a_reset_room: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind auto_exposure_gain_stepper_unit aegs_checker u_aegs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .valid_count  (valid_count)
);
